FILE: rtl/tsts_pkg.sv
package tsts_pkg;

  // default table depth
  localparam int TASK_SLOTS_DEF = 16;

  // request modes
  localparam logic [1:0] MODE_ADD      = 2'd0;
  localparam logic [1:0] MODE_DISPATCH = 2'd1;
  localparam logic [1:0] MODE_COMPLETE = 2'd2;

  // response status codes
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_FULL     = 2'd1;
  localparam logic [1:0] STATUS_EMPTY    = 2'd2;
  localparam logic [1:0] STATUS_BAD_SLOT = 2'd3;

  // per-slot state codes
  localparam logic [1:0] SLOT_IDLE       = 2'd0;
  localparam logic [1:0] SLOT_WAITING    = 2'd1;
  localparam logic [1:0] SLOT_PROCESSING = 2'd2;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] task_id;
    logic [63:0] job_handle;
    logic [63:0] exit_handle;
    logic [3:0]  slot_index;
  } req_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  slot_out;
    logic [31:0] task_id_out;
    logic [63:0] job_handle_out;
    logic [63:0] exit_handle_out;
    logic [4:0]  waiting_count;
    logic [4:0]  processing_count;
  } rsp_item_t;

  // controller to datapath
  typedef struct packed {
    logic clear_step;
    logic scan_start;
    logic scan_step;
    logic commit;
    logic load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic cnt_last;
    logic out_free;
  } stat_t;

endpackage

FILE: rtl/tsts_req_if.sv
interface tsts_req_if;
  logic                 valid;
  logic                 ready;
  tsts_pkg::req_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/tsts_rsp_if.sv
interface tsts_rsp_if;
  logic                 valid;
  logic                 ready;
  tsts_pkg::rsp_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/tsts_ctrl.sv
module tsts_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  tsts_pkg::stat_t stat,
  output tsts_pkg::cmd_t  cmd
);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_DRAIN  = 3'd3;
  localparam logic [2:0] S_COMMIT = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    unique case (state)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (stat.cnt_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.scan_start = 1'b1;
          state_next     = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.cnt_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

endmodule

FILE: rtl/tsts_dp.sv
module tsts_dp #(
  parameter int TASK_SLOTS = tsts_pkg::TASK_SLOTS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  tsts_pkg::cmd_t      cmd,
  output tsts_pkg::stat_t     stat,
  input  tsts_pkg::req_item_t req_data,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output tsts_pkg::rsp_item_t rsp_data
);

  localparam int SW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int CW = $clog2(TASK_SLOTS + 1);
  localparam int IW = (SW > 4) ? SW : 4;

  typedef struct packed {
    logic [31:0] task_id;
    logic [63:0] job_handle;
    logic [63:0] exit_handle;
  } entry_t;

  typedef struct packed {
    logic [1:0]  slot_state;
    logic [31:0] stamp;
  } meta_t;

  // slot memories
  meta_t  meta_mem [TASK_SLOTS];
  entry_t entry_mem [TASK_SLOTS];

  logic [CW-1:0]       cnt;
  tsts_pkg::req_item_t item;
  meta_t               rd_meta;
  entry_t              rd_entry;
  logic                ev_valid;
  logic [SW-1:0]       ev_idx;
  logic                found;
  logic [SW-1:0]       best;
  logic [31:0]         best_stamp;
  logic [31:0]         arrival;
  logic [4:0]          waiting_total;
  logic [4:0]          processing_total;
  logic [1:0]          res_status;
  logic [3:0]          res_slot;
  logic                disp_ok;

  logic                hit;
  logic                meta_we;
  logic [SW-1:0]       meta_waddr;
  meta_t               meta_wdata;
  logic [31:0]         arrival_inc;

  assign stat.cnt_last = (cnt == CW'(TASK_SLOTS - 1));
  assign stat.out_free = !rsp_valid || rsp_ready;
  assign arrival_inc   = arrival + 32'd1;

  // slot counter shared by the clearing pass and the scan
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.clear_step || cmd.scan_step) begin
      cnt <= stat.cnt_last ? '0 : cnt + CW'(1);
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      item <= req_data;
    end
  end

  // scan read stage, one slot a cycle
  always_ff @(posedge clk) begin
    if (cmd.scan_step) begin
      rd_meta <= meta_mem[cnt[SW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ev_valid <= 1'b0;
    end else begin
      ev_valid <= cmd.scan_step;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_step) begin
      ev_idx <= cnt[SW-1:0];
    end
  end

  // match rule of the current mode
  always_comb begin
    hit = 1'b0;
    case (item.mode)
      tsts_pkg::MODE_ADD: begin
        hit = !found && (rd_meta.slot_state == tsts_pkg::SLOT_IDLE);
      end
      tsts_pkg::MODE_DISPATCH: begin
        hit = (rd_meta.slot_state == tsts_pkg::SLOT_WAITING) &&
              (!found || (rd_meta.stamp < best_stamp));
      end
      tsts_pkg::MODE_COMPLETE: begin
        hit = (rd_meta.slot_state == tsts_pkg::SLOT_PROCESSING) &&
              (IW'(ev_idx) == IW'(item.slot_index));
      end
      default: begin
        hit = 1'b0;
      end
    endcase
  end

  // best candidate so far
  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      found <= 1'b0;
    end else if (ev_valid && hit) begin
      found      <= 1'b1;
      best       <= ev_idx;
      best_stamp <= rd_meta.stamp;
    end
  end

  // state memory write port: clearing pass or commit
  always_comb begin
    meta_we    = 1'b0;
    meta_waddr = best;
    meta_wdata = '0;
    if (cmd.clear_step) begin
      meta_we    = 1'b1;
      meta_waddr = cnt[SW-1:0];
      meta_wdata = '{slot_state: tsts_pkg::SLOT_IDLE, stamp: 32'd0};
    end else if (cmd.commit && found) begin
      case (item.mode)
        tsts_pkg::MODE_ADD: begin
          meta_we    = 1'b1;
          meta_wdata = '{slot_state: tsts_pkg::SLOT_WAITING, stamp: arrival_inc};
        end
        tsts_pkg::MODE_DISPATCH: begin
          meta_we    = 1'b1;
          meta_wdata = '{slot_state: tsts_pkg::SLOT_PROCESSING, stamp: best_stamp};
        end
        tsts_pkg::MODE_COMPLETE: begin
          meta_we    = 1'b1;
          meta_wdata = '{slot_state: tsts_pkg::SLOT_IDLE, stamp: 32'd0};
        end
        default: begin
          meta_we = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (meta_we) begin
      meta_mem[meta_waddr] <= meta_wdata;
    end
  end

  // task entry memory: written on add, read on dispatch
  always_ff @(posedge clk) begin
    if (cmd.commit && found && (item.mode == tsts_pkg::MODE_ADD)) begin
      entry_mem[best] <= '{task_id: item.task_id, job_handle: item.job_handle,
                           exit_handle: item.exit_handle};
    end
    if (cmd.commit && found && (item.mode == tsts_pkg::MODE_DISPATCH)) begin
      rd_entry <= entry_mem[best];
    end
  end

  // counters and totals
  always_ff @(posedge clk) begin
    if (rst) begin
      arrival          <= '0;
      waiting_total    <= '0;
      processing_total <= '0;
    end else if (cmd.commit && found) begin
      case (item.mode)
        tsts_pkg::MODE_ADD: begin
          arrival       <= arrival_inc;
          waiting_total <= waiting_total + 5'd1;
        end
        tsts_pkg::MODE_DISPATCH: begin
          waiting_total    <= waiting_total - 5'd1;
          processing_total <= processing_total + 5'd1;
        end
        tsts_pkg::MODE_COMPLETE: begin
          processing_total <= processing_total - 5'd1;
        end
        default: begin
          arrival <= arrival;
        end
      endcase
    end
  end

  // result status and slot
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      disp_ok    <= found && (item.mode == tsts_pkg::MODE_DISPATCH);
      res_status <= tsts_pkg::STATUS_OK;
      res_slot   <= 4'd0;
      case (item.mode)
        tsts_pkg::MODE_ADD: begin
          res_status <= found ? tsts_pkg::STATUS_OK : tsts_pkg::STATUS_FULL;
          res_slot   <= found ? 4'(best) : 4'd0;
        end
        tsts_pkg::MODE_DISPATCH: begin
          res_status <= found ? tsts_pkg::STATUS_OK : tsts_pkg::STATUS_EMPTY;
          res_slot   <= found ? 4'(best) : 4'd0;
        end
        tsts_pkg::MODE_COMPLETE: begin
          res_status <= found ? tsts_pkg::STATUS_OK : tsts_pkg::STATUS_BAD_SLOT;
          res_slot   <= item.slot_index;
        end
        default: begin
          res_status <= tsts_pkg::STATUS_OK;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.load_out) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      rsp_data.status           <= res_status;
      rsp_data.slot_out         <= res_slot;
      rsp_data.task_id_out      <= disp_ok ? rd_entry.task_id : 32'd0;
      rsp_data.job_handle_out   <= disp_ok ? rd_entry.job_handle : 64'd0;
      rsp_data.exit_handle_out  <= disp_ok ? rd_entry.exit_handle : 64'd0;
      rsp_data.waiting_count    <= waiting_total;
      rsp_data.processing_count <= processing_total;
    end
  end

endmodule

FILE: rtl/task_slot_table_scheduler.sv
// task slot table scheduler
// req channel (valid/ready) carries one request beat: mode selects add, dispatch
// or complete, with task id, two 64-bit handles and a slot index.
// rsp channel (valid/ready) returns exactly one beat per request: status, slot,
// the dispatched task id and handles, and the waiting and processing totals.
// each request scans every slot of the table once, one slot per cycle through the
// registered read port of the slot state memory, then drains, commits and loads
// the response into the output register; only then is a new request taken.
// after reset a clearing pass marks every slot idle, one slot at a time; req
// ready stays low during it. the arrival counter and totals reset to zero.
// the response sits in an output register; a new request is accepted while it
// waits, and if the receiver stalls, the next response holds at its commit until
// the register is free, so no beat is lost or repeated.
module task_slot_table_scheduler #(
  parameter int TASK_SLOTS = tsts_pkg::TASK_SLOTS_DEF
) (
  input logic        clk,
  input logic        rst,
  tsts_req_if.sink   req,
  tsts_rsp_if.source rsp
);

  tsts_pkg::cmd_t      cmd;
  tsts_pkg::stat_t     stat;
  logic                req_ready;
  logic                rsp_valid;
  tsts_pkg::rsp_item_t rsp_data;

  assign req.ready = req_ready;
  assign rsp.valid = rsp_valid;
  assign rsp.data  = rsp_data;

  // sequencer
  tsts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // slot memories, scan and result
  tsts_dp #(
    .TASK_SLOTS (TASK_SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .req_data  (req.data),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp.ready),
    .rsp_data  (rsp_data)
  );

endmodule

FILE: rtl/tsts_chk.sv
module tsts_chk #(
  parameter int TASK_SLOTS = tsts_pkg::TASK_SLOTS_DEF
) (
  input logic                clk,
  input logic                rst,
  input logic                req_valid,
  input logic                req_ready,
  input logic                rsp_valid,
  input logic                rsp_ready,
  input tsts_pkg::rsp_item_t rsp_data
);

  logic [5:0] occupied;
  assign occupied = 6'(rsp_data.waiting_count) + 6'(rsp_data.processing_count);

  // a stalled response holds
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
    else $error("stalled response changed");

  // one request at a time
  assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken during a scan");

  // totals never exceed the table
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (TASK_SLOTS > 31) || (int'(occupied) <= TASK_SLOTS))
    else $error("totals exceed table size");

  // full means every slot is in use
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_data.status == tsts_pkg::STATUS_FULL) |->
      (TASK_SLOTS > 31) || (int'(occupied) == TASK_SLOTS))
    else $error("full reported with a free slot");

  // nothing waiting means the waiting total is zero
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_data.status == tsts_pkg::STATUS_EMPTY) |->
      (rsp_data.waiting_count == 5'd0) || (TASK_SLOTS > 31))
    else $error("empty reported with waiting slots");

endmodule

bind task_slot_table_scheduler tsts_chk #(
  .TASK_SLOTS (TASK_SLOTS)
) u_tsts_chk (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_data  (rsp.data)
);

FILE: test/task_slot_table_scheduler_checker.sv
`timescale 1ns / 100ps

// watches both channels, predicts every response and compares it field by field
module task_slot_table_scheduler_checker
  import tsts_pkg::*;
#(
  parameter int TASK_SLOTS = TASK_SLOTS_DEF
) (
  input  logic clk,
  input  logic rst,
  tsts_req_if  req,
  tsts_rsp_if  rsp,
  output int   errors,
  output int   pending,
  output int   checked,
  output int   fulls,
  output int   empties,
  output int   bad_slots
);

  // shadow copy of the slot table
  logic [1:0]  slot_st    [TASK_SLOTS];
  logic [31:0] slot_stamp [TASK_SLOTS];
  logic [31:0] slot_tid   [TASK_SLOTS];
  logic [63:0] slot_job   [TASK_SLOTS];
  logic [63:0] slot_exit  [TASK_SLOTS];
  logic [31:0] arrivals;
  logic [4:0]  n_waiting;
  logic [4:0]  n_busy;

  // responses still owed by the block, oldest first
  rsp_item_t   due_rsp_q [$];

  // one request against the shadow table, returns the response it must produce
  function automatic rsp_item_t table_step(input req_item_t r);
    rsp_item_t o;
    int        i;
    int        pick;
    o    = '0;
    pick = -1;
    case (r.mode)
      MODE_ADD: begin
        // lowest-numbered idle slot
        for (i = 0; i < TASK_SLOTS; i++)
          if (pick < 0 && slot_st[i] == SLOT_IDLE) pick = i;
        if (pick < 0) begin
          o.status = STATUS_FULL;
        end else begin
          arrivals         = arrivals + 32'd1;
          slot_st[pick]    = SLOT_WAITING;
          slot_stamp[pick] = arrivals;
          slot_tid[pick]   = r.task_id;
          slot_job[pick]   = r.job_handle;
          slot_exit[pick]  = r.exit_handle;
          n_waiting        = n_waiting + 5'd1;
          o.slot_out       = 4'(pick);
        end
      end
      MODE_DISPATCH: begin
        // smallest stamp wins, ties go to the lower slot
        for (i = 0; i < TASK_SLOTS; i++)
          if (slot_st[i] == SLOT_WAITING && (pick < 0 || slot_stamp[i] < slot_stamp[pick]))
            pick = i;
        if (pick < 0) begin
          o.status = STATUS_EMPTY;
        end else begin
          slot_st[pick]     = SLOT_PROCESSING;
          n_waiting         = n_waiting - 5'd1;
          n_busy            = n_busy + 5'd1;
          o.slot_out        = 4'(pick);
          o.task_id_out     = slot_tid[pick];
          o.job_handle_out  = slot_job[pick];
          o.exit_handle_out = slot_exit[pick];
        end
      end
      MODE_COMPLETE: begin
        o.slot_out = r.slot_index;
        if (int'(r.slot_index) < TASK_SLOTS && slot_st[r.slot_index] == SLOT_PROCESSING) begin
          slot_st[r.slot_index] = SLOT_IDLE;
          n_busy                = n_busy - 5'd1;
        end else begin
          o.status = STATUS_BAD_SLOT;
        end
      end
      // unused mode leaves the table alone
      default: ;
    endcase
    o.waiting_count    = n_waiting;
    o.processing_count = n_busy;
    return o;
  endfunction

  task automatic report_fault(input string msg);
    errors++;
    $display("%0t checker: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want)
      report_fault($sformatf("response %0d: %s got 0x%0h, want 0x%0h",
                             checked, name, got, want));
  endtask

  always @(posedge clk) begin : watch
    rsp_item_t want;
    int        i;
    if (rst) begin
      for (i = 0; i < TASK_SLOTS; i++) begin
        slot_st[i]    = SLOT_IDLE;
        slot_stamp[i] = '0;
        slot_tid[i]   = '0;
        slot_job[i]   = '0;
        slot_exit[i]  = '0;
      end
      arrivals  = '0;
      n_waiting = '0;
      n_busy    = '0;
      due_rsp_q.delete();
    end else begin
      // response beat against the oldest prediction
      if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
        if (due_rsp_q.size() == 0) begin
          report_fault($sformatf("response beat with nothing due: 0x%0h", rsp.data));
        end else begin
          want = due_rsp_q.pop_front();
          check_field("status", rsp.data.status, want.status);
          check_field("slot_out", rsp.data.slot_out, want.slot_out);
          check_field("task_id_out", rsp.data.task_id_out, want.task_id_out);
          check_field("job_handle_out", rsp.data.job_handle_out, want.job_handle_out);
          check_field("exit_handle_out", rsp.data.exit_handle_out, want.exit_handle_out);
          check_field("waiting_count", rsp.data.waiting_count, want.waiting_count);
          check_field("processing_count", rsp.data.processing_count, want.processing_count);
          if (want.status == STATUS_FULL) fulls++;
          if (want.status == STATUS_EMPTY) empties++;
          if (want.status == STATUS_BAD_SLOT) bad_slots++;
          checked++;
        end
      end
      // request beat updates the shadow table
      if (req.valid === 1'b1 && req.ready === 1'b1)
        due_rsp_q.push_back(table_step(req.data));
    end
    pending <= due_rsp_q.size();
  end

endmodule

FILE: test/task_slot_table_scheduler_tb.sv
`timescale 1ns / 100ps

module task_slot_table_scheduler_tb;
  import tsts_pkg::*;

  localparam logic [1:0] MODE_UNUSED  = 2'd3;
  localparam int         IDLE_LIMIT   = 4000;
  localparam int         TAIL_CYCLES  = 2 * (TASK_SLOTS_DEF + 4);
  localparam int         RANDOM_ITEMS = 630;

  // request mixes for the random phases
  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_RETIRE, MIX_EVEN} mix_t;
  // receiver behaviors
  typedef enum int {RX_OPEN, RX_PATTERN, RX_LIGHT, RX_HEAVY} rx_mode_t;

  logic clk;
  logic rst;

  tsts_req_if req ();
  tsts_rsp_if rsp ();

  int errors;
  int pending;
  int checked;
  int fulls;
  int empties;
  int bad_slots;
  int sent;
  int burst_left;
  int hold_asked;

  task_slot_table_scheduler dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  task_slot_table_scheduler_checker chk (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp       (rsp),
    .errors    (errors),
    .pending   (pending),
    .checked   (checked),
    .fulls     (fulls),
    .empties   (empties),
    .bad_slots (bad_slots)
  );

  // 12 ns clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic req_item_t mk_req(input logic [1:0] mode, input logic [31:0] tid,
                                       input logic [63:0] job, input logic [63:0] ext,
                                       input logic [3:0] idx);
    req_item_t r;
    r.mode        = mode;
    r.task_id     = tid;
    r.job_handle  = job;
    r.exit_handle = ext;
    r.slot_index  = idx;
    return r;
  endfunction

  function automatic req_item_t rand_req(input mix_t mix);
    req_item_t r;
    int        roll;
    int        add_lim;
    int        disp_lim;
    int        comp_lim;
    case (mix)
      MIX_FILL:   begin add_lim = 75; disp_lim = 88; comp_lim = 96; end
      MIX_DRAIN:  begin add_lim = 15; disp_lim = 75; comp_lim = 95; end
      MIX_RETIRE: begin add_lim = 20; disp_lim = 40; comp_lim = 95; end
      default:    begin add_lim = 35; disp_lim = 65; comp_lim = 96; end
    endcase
    roll          = $urandom_range(0, 99);
    r.mode        = (roll < add_lim)  ? MODE_ADD :
                    (roll < disp_lim) ? MODE_DISPATCH :
                    (roll < comp_lim) ? MODE_COMPLETE : MODE_UNUSED;
    r.task_id     = $urandom;
    r.job_handle  = {$urandom, $urandom};
    r.exit_handle = {$urandom, $urandom};
    r.slot_index  = 4'($urandom_range(0, 15));
    return r;
  endfunction

  // drive one request beat and wait for it to be taken; valid stays up
  task automatic send_req(input req_item_t item);
    @(negedge clk);
    req.valid <= 1'b1;
    req.data  <= item;
    @(posedge clk);
    while (req.ready !== 1'b1) @(posedge clk);
    sent++;
  endtask

  // burst bookkeeping, random gap once a burst is used up
  task automatic pace();
    int gap;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      if (gap > 0) begin
        @(negedge clk);
        req.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  // stop offering until every owed response is back
  task automatic wait_drain();
    @(negedge clk);
    req.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // receiver: stall patterns plus long hold-offs on request
  initial begin : receiver
    int         seg_left;
    int         hold_cnt;
    int         served;
    rx_mode_t   rx_mode;
    logic [7:0] pat;
    seg_left  = 0;
    hold_cnt  = 0;
    served    = 0;
    rx_mode   = RX_OPEN;
    pat       = 8'hff;
    rsp.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cnt == 0 && served != hold_asked) begin
        served++;
        hold_cnt = $urandom_range(300, 500);
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        rsp.ready <= 1'b0;
      end else begin
        if (seg_left == 0) begin
          rx_mode  = rx_mode_t'($urandom_range(0, 3));
          seg_left = $urandom_range(20, 200);
          pat      = 8'($urandom) | 8'h01;
        end
        seg_left--;
        case (rx_mode)
          RX_OPEN: rsp.ready <= 1'b1;
          RX_PATTERN: begin
            rsp.ready <= pat[0];
            pat = {pat[0], pat[7:1]};
          end
          RX_LIGHT: rsp.ready <= ($urandom_range(0, 3) != 0);
          default:  rsp.ready <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  // watchdog on cycles without any accepted beat
  initial begin : watchdog
    int idle_run;
    idle_run = 0;
    while (idle_run < IDLE_LIMIT) begin
      @(posedge clk);
      if ((req.valid === 1'b1 && req.ready === 1'b1) ||
          (rsp.valid === 1'b1 && rsp.ready === 1'b1))
        idle_run = 0;
      else
        idle_run++;
    end
    $display("timeout: no beat accepted for %0d cycles", IDLE_LIMIT);
    $display("task_slot_table_scheduler_tb: done, errors");
    $finish;
  end

  // stimulus
  initial begin : stimulus
    logic [63:0] ones;
    int          directed;
    int          phase;
    int          len;
    int          k;
    mix_t        mix;
    ones       = '1;
    sent       = 0;
    burst_left = 0;
    hold_asked = 0;
    rst        = 1'b1;
    req.valid  = 1'b0;
    req.data   = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty table, bad slots, extremes, oldest-first order
    send_req(mk_req(MODE_DISPATCH, '0, '0, '0, 4'd0));
    send_req(mk_req(MODE_COMPLETE, '0, '0, '0, 4'd0));
    send_req(mk_req(MODE_COMPLETE, '1, ones, ones, 4'd15));
    send_req(mk_req(MODE_UNUSED, '1, ones, ones, 4'd15));
    send_req(mk_req(MODE_ADD, '0, '0, '0, 4'd0));
    send_req(mk_req(MODE_ADD, '1, ones, ones, 4'd15));
    send_req(mk_req(MODE_ADD, 32'ha5a5_5a5a, 64'h0123_4567_89ab_cdef,
                    64'hfedc_ba98_7654_3210, 4'd7));
    send_req(mk_req(MODE_DISPATCH, '1, ones, ones, 4'd15));
    send_req(mk_req(MODE_UNUSED, '0, '0, '0, 4'd0));
    send_req(mk_req(MODE_DISPATCH, '0, '0, '0, 4'd0));
    send_req(mk_req(MODE_COMPLETE, '0, '0, '0, 4'd1));
    send_req(mk_req(MODE_COMPLETE, '0, '0, '0, 4'd1));
    // waiting slot is not processing yet
    send_req(mk_req(MODE_COMPLETE, '0, '0, '0, 4'd2));
    // refills slot 1 with a newer stamp than slot 2
    send_req(mk_req(MODE_ADD, 32'h8000_0001, 64'h8000_0000_0000_0001,
                    64'h7fff_ffff_ffff_fffe, 4'd0));
    send_req(mk_req(MODE_DISPATCH, '0, '0, '0, 4'd0));
    send_req(mk_req(MODE_DISPATCH, '0, '0, '0, 4'd0));
    send_req(mk_req(MODE_DISPATCH, '0, '0, '0, 4'd0));
    send_req(mk_req(MODE_COMPLETE, '0, '0, '0, 4'd0));
    send_req(mk_req(MODE_COMPLETE, '0, '0, '0, 4'd2));
    send_req(mk_req(MODE_COMPLETE, '0, '0, '0, 4'd1));
    send_req(mk_req(MODE_COMPLETE, '0, '0, '0, 4'd3));
    directed = sent;
    wait_drain();

    // random phases with shifting request mixes
    phase = 0;
    while (sent < directed + RANDOM_ITEMS) begin
      mix = (phase == 0) ? MIX_FILL : mix_t'($urandom_range(0, 3));
      len = $urandom_range(30, 80);
      for (k = 0; k < len && sent < directed + RANDOM_ITEMS; k++) begin
        send_req(rand_req(mix));
        // long receiver hold-off while the sender keeps pushing
        if (k == 10 && (phase == 1 || phase == 5)) begin
          hold_asked++;
          burst_left = 12;
        end
        pace();
      end
      if (phase % 3 == 2) wait_drain();
      phase++;
    end

    wait_drain();
    repeat (TAIL_CYCLES) @(negedge clk);
    $display("sent %0d requests (%0d directed), checked %0d responses",
             sent, directed, checked);
    $display("table full seen %0d times, nothing waiting %0d times, bad slot %0d times",
             fulls, empties, bad_slots);
    if (errors == 0)
      $display("task_slot_table_scheduler_tb: done, clean");
    else
      $display("task_slot_table_scheduler_tb: done, errors");
    $finish;
  end

endmodule
